// ===== rtl/lmt_pkg.sv =====
// Shared types and constants for the LCD line mode timer.
package lmt_pkg;

    // Scanline timing, in the units of the elapsed count that each request carries
    localparam logic [8:0] LINE_CYCLES     = 9'd456;
    localparam logic [8:0] OAM_CYCLES      = 9'd80;
    localparam logic [8:0] TRANSFER_CYCLES = 9'd172;
    localparam logic [8:0] OAM_BOUND       = LINE_CYCLES - OAM_CYCLES;
    localparam logic [8:0] XFER_BOUND      = OAM_BOUND - TRANSFER_CYCLES;

    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    localparam int CYCLES_W = 8;
    localparam int LINE_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAT_IRQ_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_LINE   = 2'd2;

    // Bits of the STAT interrupt enable register
    localparam int IRQ_EN_HBLANK = 0;
    localparam int IRQ_EN_VBLANK = 1;
    localparam int IRQ_EN_OAM    = 2;
    localparam int IRQ_EN_COINC  = 3;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        logic              display_enable;
        logic [3:0]        stat_irq_enables;
        logic [LINE_W-1:0] compare_line;
    } cfg_t;

    // Packed with line_number in the lowest bits
    typedef struct packed {
        logic              render_request;
        logic              vblank_irq;
        logic              stat_irq;
        logic              coincidence;
        lcd_mode_t         lcd_mode;
        logic [LINE_W-1:0] line_number;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/lmt_cfg_regs.sv =====
// Configuration register file of the LCD line mode timer.
module lmt_cfg_regs
    import lmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DISPLAY_ENABLE: cfg_next.display_enable   = cfg_wdata[0];
                REG_STAT_IRQ_EN:    cfg_next.stat_irq_enables = cfg_wdata[3:0];
                REG_COMPARE_LINE:   cfg_next.compare_line     = cfg_wdata[LINE_W-1:0];
                default:            cfg_next = cfg_reg;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_enable   <= 1'b1;
            cfg_reg.stat_irq_enables <= '0;
            cfg_reg.compare_line     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lmt_step.sv =====
// Line timing state and the per-request mode, interrupt and line update.
module lmt_step
    import lmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [CYCLES_W-1:0] cycles,
    input  cfg_t                cfg,
    output result_t             res
);

    logic [8:0]        countdown_reg, countdown_next;
    logic [LINE_W-1:0] line_reg, line_next;
    lcd_mode_t         mode_reg, mode_next;

    lcd_mode_t         mode;
    logic              coinc;
    logic              stat;
    logic              reload;
    logic [LINE_W-1:0] line_inc;

    always_comb
    begin
        // Mode from the countdown before this request's decrement
        if (line_reg >= VBLANK_LINE)
            mode = MODE_VBLANK;
        else if (countdown_reg >= OAM_BOUND)
            mode = MODE_OAM;
        else if (countdown_reg >= XFER_BOUND)
            mode = MODE_TRANSFER;
        else
            mode = MODE_HBLANK;

        coinc = (line_reg == cfg.compare_line);

        stat = 1'b0;
        if (mode != mode_reg)
        begin
            case (mode)
                MODE_HBLANK: stat = cfg.stat_irq_enables[IRQ_EN_HBLANK];
                MODE_VBLANK: stat = cfg.stat_irq_enables[IRQ_EN_VBLANK];
                MODE_OAM:    stat = cfg.stat_irq_enables[IRQ_EN_OAM];
                default:     stat = 1'b0;  // transfer has no enable
            endcase
        end
        if (coinc && cfg.stat_irq_enables[IRQ_EN_COINC])
            stat = 1'b1;

        reload   = ({1'b0, cycles} >= countdown_reg);
        line_inc = line_reg + 8'd1;

        res.line_number    = line_reg;
        res.lcd_mode       = mode;
        res.coincidence    = coinc;
        res.stat_irq       = stat;
        res.vblank_irq     = 1'b0;
        res.render_request = 1'b0;

        countdown_next = countdown_reg - {1'b0, cycles};
        line_next      = line_reg;
        mode_next      = mode;

        if (reload)
        begin
            countdown_next     = LINE_CYCLES;
            res.vblank_irq     = (line_inc == VBLANK_LINE);
            res.render_request = (line_inc < VBLANK_LINE);
            line_next          = (line_inc > LAST_LINE) ? '0 : line_inc;
        end
        res.line_number = line_next;

        // Display off: park on line 0 in vblank, no requests
        if (!cfg.display_enable)
        begin
            countdown_next = LINE_CYCLES;
            line_next      = '0;
            mode_next      = MODE_VBLANK;
            res            = '0;
            res.lcd_mode   = MODE_VBLANK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= '0;
            line_reg      <= '0;
            mode_reg      <= MODE_HBLANK;
        end
        else if (step_en)
        begin
            countdown_reg <= countdown_next;
            line_reg      <= line_next;
            mode_reg      <= mode_next;
        end
    end

endmodule

// ===== rtl/lcd_line_mode_timer.sv =====
// Top level of the LCD line mode timer: input register, step logic, result register.
//
// Each request carries the CPU time elapsed since the previous one and
// yields exactly one result: the scanline after the step, the LCD mode seen
// before the countdown moved, the line-compare coincidence flag and the
// STAT, vblank and render requests. The block takes one request per clock while
// s_tready is high and returns results in order through the input register, then
// the result register; all state is updated in the single step stage between them,
// so consecutive requests see each other's effect. Both stream sides may stall
// freely; s_tready is high when the input register is empty or the result
// register can take a new result. Configuration is written through cfg_we/cfg_index/
// cfg_wdata and should change only while no request is in flight. After reset
// the countdown is zero, so the first request advances to line 1.
module lcd_line_mode_timer
    import lmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CYCLES_W-1:0]    s_tdata,   // [7:0] cycles_elapsed

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] line_number, [9:8] lcd_mode, [10] coincidence, [11] stat_irq,
    // [12] vblank_irq, [13] render_request, [15:14] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg;

    logic                in_valid_reg;
    logic [CYCLES_W-1:0] in_cycles_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;
    result_t             step_res;

    logic out_free;
    logic step_en;

    // Result register can take a new value when empty or draining now
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    lmt_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmt_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .cycles  (in_cycles_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_cycles_reg <= s_tdata;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_data_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_data_reg};

endmodule
